// ----- hdl/pid_controller_step_defines.svh -----
// Assertion macros for the PID controller step checker.
`ifndef PID_CONTROLLER_STEP_DEFINES_SVH
`define PID_CONTROLLER_STEP_DEFINES_SVH

// Same-cycle implication, sampled on clk, held off during reset.
`define PCS_ASSERT_IMP(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("pid_controller_step check failed");

// Next-cycle implication, sampled on clk, held off during reset.
`define PCS_ASSERT_NXT(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("pid_controller_step check failed");

`endif

// ----- hdl/pcs_pkg.sv -----
// Shared types and constants for the PID controller step.
`timescale 1ns / 1ps
`default_nettype none
package pcs_pkg;

    localparam int MUL_A_W = 48;
    localparam int MUL_B_W = 32;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int DIV_N_W = 52;
    localparam int DIV_D_W = 32;

    typedef enum logic [4:0] {
        S_IDLE,
        S_WA,
        S_WA_W,
        S_WB,
        S_WB_W,
        S_SAT,
        S_VEL,
        S_VEL_W,
        S_IZ,
        S_IM_W,
        S_ID,
        S_ID_W,
        S_MP,
        S_MP_W,
        S_MD,
        S_MD_W,
        S_MI,
        S_MI_W,
        S_OUT
    } pcs_state_t;

    typedef enum logic [2:0] {
        CFG_KP,
        CFG_KI,
        CFG_KD,
        CFG_IZONE,
        CFG_INTEG_LOW,
        CFG_INTEG_HIGH,
        CFG_INPUT_RANGE,
        CFG_POS_TOL
    } pcs_cfg_t;

endpackage
`default_nettype wire

// ----- hdl/pcs_mul.sv -----
// Bit-serial shift-add multiplier: signed multiplicand, unsigned multiplier.
`timescale 1ns / 1ps
`default_nettype none
module pcs_mul
    import pcs_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic signed [MUL_A_W-1:0]  a,
    input  wire logic        [MUL_B_W-1:0]  b,
    output logic                            done,
    output logic signed      [MUL_P_W-1:0]  prod
);

    localparam int CNT_W = $clog2(MUL_B_W + 1);

    logic signed [MUL_P_W-1:0] acc_reg;
    logic signed [MUL_P_W-1:0] mcand_reg;
    logic        [MUL_B_W-1:0] mplier_reg;
    logic        [CNT_W-1:0]   cnt_reg;
    logic                      run_reg;
    logic                      done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(MUL_B_W);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg    <= '0;
            mcand_reg  <= MUL_P_W'(a);
            mplier_reg <= b;
        end
        else if (run_reg)
        begin
            if (mplier_reg[0])
            begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= mcand_reg <<< 1;
            mplier_reg <= mplier_reg >> 1;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule
`default_nettype wire

// ----- hdl/pcs_div.sv -----
// Bit-serial restoring divider for unsigned operands.
`timescale 1ns / 1ps
`default_nettype none
module pcs_div
    import pcs_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [DIV_N_W-1:0] dividend,
    input  wire logic [DIV_D_W-1:0] divisor,
    output logic                    done,
    output logic      [DIV_N_W-1:0] quo,
    output logic      [DIV_D_W-1:0] rem
);

    localparam int CNT_W = $clog2(DIV_N_W + 1);

    logic [DIV_D_W-1:0] rem_reg;
    logic [DIV_N_W-1:0] quo_reg;
    logic [DIV_D_W-1:0] dvs_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               run_reg;
    logic               done_reg;
    logic [DIV_D_W:0]   sh;
    logic [DIV_D_W+1:0] diff;
    logic               borrow;

    always_comb
    begin
        sh     = {rem_reg, quo_reg[DIV_N_W-1]};
        diff   = {1'b0, sh} - {2'b00, dvs_reg};
        borrow = diff[DIV_D_W+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(DIV_N_W);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (run_reg)
        begin
            rem_reg <= borrow ? sh[DIV_D_W-1:0] : diff[DIV_D_W-1:0];
            quo_reg <= {quo_reg[DIV_N_W-2:0], ~borrow};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule
`default_nettype wire

// ----- hdl/pid_controller_step.sv -----
// Top level of the PID controller step: sequencer, registers, state and result stage.
`timescale 1ns / 1ps
`default_nettype none
// One request at a time: error, optional wrap into the continuous span, velocity,
// integrator update and the three gain products run in order through one serial
// multiplier (one multiplier bit a cycle) and one serial divider (one quotient
// bit a cycle). The result waits in an output register, and a new request is
// taken while it waits.
module pid_controller_step
    import pcs_pkg::*;
#(
    parameter int TICKS_PER_SECOND = 1000,
    parameter int VEL_TOLERANCE    = 2147483647
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [31:0] measurement,
    input  wire logic signed [31:0] setpoint,
    input  wire logic        [15:0] dt_ticks,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed      [47:0] drive,
    output logic                    at_setpoint,
    output logic                    zero_interval,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic        [2:0]  cfg_index,
    input  wire logic        [47:0] cfg_data
);

    localparam logic signed [20:0] TPS_S  = 21'(TICKS_PER_SECOND);
    localparam logic        [31:0] TPS_U  = 32'(TICKS_PER_SECOND);
    localparam logic        [32:0] VTOL_U = 33'(VEL_TOLERANCE);
    localparam logic signed [63:0] MAX32  = 64'sd2147483647;
    localparam logic signed [63:0] MIN32  = -64'sd2147483648;
    localparam logic signed [63:0] MAX48  = 64'sd140737488355327;
    localparam logic signed [63:0] MIN48  = -64'sd140737488355328;
    localparam logic signed [63:0] BIG60  = 64'sd1152921504606846976;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > MAX32)
        begin
            r = 32'sh7FFFFFFF;
        end
        else if (x < MIN32)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = x[31:0];
        end
        return r;
    endfunction

    pcs_state_t state_reg, state_next;

    logic        [31:0] kp_reg, ki_reg, kd_reg, range_reg;
    logic        [30:0] izone_reg, pos_tol_reg;
    logic signed [47:0] ilow_reg, ihigh_reg;

    logic signed [34:0] e_reg;
    logic signed [31:0] e32_reg;
    logic signed [31:0] v_reg;
    logic signed [31:0] last_error_reg;
    logic signed [47:0] integral_reg;
    logic        [15:0] dt_reg;
    logic               zi_reg;
    logic               neg_reg;
    logic        [51:0] pmag_reg;
    logic signed [63:0] acc_reg;

    logic               out_valid_reg;
    logic signed [47:0] drive_reg;
    logic               at_reg;
    logic               zo_reg;

    logic                      mul_start;
    logic signed [MUL_A_W-1:0] mul_a;
    logic        [MUL_B_W-1:0] mul_b;
    logic                      mul_done;
    logic signed [MUL_P_W-1:0] mul_prod;
    logic                      div_start;
    logic        [DIV_N_W-1:0] div_dvd;
    logic        [DIV_D_W-1:0] div_dvs;
    logic                      div_done;
    logic        [DIV_N_W-1:0] div_quo;
    logic        [DIV_D_W-1:0] div_rem;

    logic signed [34:0] lo_s, hi_s;
    logic signed [35:0] xa, xb;
    logic signed [35:0] xsel;
    logic signed [34:0] srem;
    logic signed [32:0] dvel;
    logic signed [53:0] num;
    logic signed [53:0] sq;
    logic signed [32:0] e_abs, v_abs;
    logic signed [54:0] iacc;
    logic signed [47:0] iclamp;
    logic signed [63:0] prod_sh;
    logic signed [63:0] ti_sat;
    logic               res_free;

    always_comb
    begin
        lo_s    = -$signed({4'b0000, range_reg[31:1]});
        hi_s    = lo_s + $signed({3'b000, range_reg});
        xa      = 36'(e_reg) - 36'(lo_s);
        xb      = 36'(e_reg) - 36'(hi_s);
        xsel    = (state_reg == S_WA) ? xa : xb;
        srem    = neg_reg ? -$signed({3'b000, div_rem}) : $signed({3'b000, div_rem});
        dvel    = 33'(e32_reg) - 33'(last_error_reg);
        num     = 54'(dvel) * 54'(TPS_S);
        sq      = neg_reg ? -$signed({2'b00, div_quo}) : $signed({2'b00, div_quo});
        e_abs   = (e32_reg < 0) ? -33'(e32_reg) : 33'(e32_reg);
        v_abs   = (v_reg < 0) ? -33'(v_reg) : 33'(v_reg);
        iacc    = 55'(integral_reg) + 55'(sq);
        if (iacc < 55'(ilow_reg))
        begin
            iclamp = ilow_reg;
        end
        else if (iacc > 55'(ihigh_reg))
        begin
            iclamp = ihigh_reg;
        end
        else
        begin
            iclamp = iacc[47:0];
        end
        prod_sh = 64'(mul_prod >>> 16);
        if (prod_sh > BIG60)
        begin
            ti_sat = BIG60;
        end
        else if (prod_sh < -BIG60)
        begin
            ti_sat = -BIG60;
        end
        else
        begin
            ti_sat = prod_sh;
        end
        res_free = !out_valid_reg || !out_stall;
    end

    always_comb
    begin
        state_next = state_reg;
        mul_start  = 1'b0;
        mul_a      = MUL_A_W'(e32_reg);
        mul_b      = kp_reg;
        div_start  = 1'b0;
        div_dvd    = DIV_N_W'(xsel < 0 ? -xsel : xsel);
        div_dvs    = range_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (range_reg != '0) ? S_WA : S_SAT;
                end
            end
            S_WA:
            begin
                div_start  = 1'b1;
                state_next = S_WA_W;
            end
            S_WA_W:
            begin
                if (div_done)
                begin
                    state_next = S_WB;
                end
            end
            S_WB:
            begin
                div_start  = 1'b1;
                state_next = S_WB_W;
            end
            S_WB_W:
            begin
                if (div_done)
                begin
                    state_next = S_SAT;
                end
            end
            S_SAT:
            begin
                state_next = S_VEL;
            end
            S_VEL:
            begin
                div_dvd = DIV_N_W'(num < 0 ? -num : num);
                div_dvs = DIV_D_W'(dt_reg);
                if (zi_reg)
                begin
                    state_next = S_IZ;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_VEL_W;
                end
            end
            S_VEL_W:
            begin
                if (div_done)
                begin
                    state_next = S_IZ;
                end
            end
            S_IZ:
            begin
                mul_b = MUL_B_W'(dt_reg);
                if (e_abs > 33'(izone_reg))
                begin
                    state_next = S_MP;
                end
                else if (ki_reg != '0)
                begin
                    mul_start  = 1'b1;
                    state_next = S_IM_W;
                end
                else
                begin
                    state_next = S_MP;
                end
            end
            S_IM_W:
            begin
                if (mul_done)
                begin
                    state_next = S_ID;
                end
            end
            S_ID:
            begin
                div_dvd    = pmag_reg;
                div_dvs    = TPS_U;
                div_start  = 1'b1;
                state_next = S_ID_W;
            end
            S_ID_W:
            begin
                if (div_done)
                begin
                    state_next = S_MP;
                end
            end
            S_MP:
            begin
                mul_start  = 1'b1;
                state_next = S_MP_W;
            end
            S_MP_W:
            begin
                if (mul_done)
                begin
                    state_next = S_MD;
                end
            end
            S_MD:
            begin
                mul_a      = MUL_A_W'(v_reg);
                mul_b      = kd_reg;
                mul_start  = 1'b1;
                state_next = S_MD_W;
            end
            S_MD_W:
            begin
                if (mul_done)
                begin
                    state_next = S_MI;
                end
            end
            S_MI:
            begin
                mul_a      = integral_reg;
                mul_b      = ki_reg;
                mul_start  = 1'b1;
                state_next = S_MI_W;
            end
            S_MI_W:
            begin
                if (mul_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (res_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg      <= '0;
            ki_reg      <= '0;
            kd_reg      <= '0;
            izone_reg   <= 31'h7FFFFFFF;
            ilow_reg    <= 48'sh800000000000;
            ihigh_reg   <= 48'sh7FFFFFFFFFFF;
            range_reg   <= '0;
            pos_tol_reg <= 31'd3277;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (pcs_cfg_t'(cfg_index))
                CFG_KP:          kp_reg      <= cfg_data[31:0];
                CFG_KI:          ki_reg      <= cfg_data[31:0];
                CFG_KD:          kd_reg      <= cfg_data[31:0];
                CFG_IZONE:       izone_reg   <= cfg_data[30:0];
                CFG_INTEG_LOW:   ilow_reg    <= cfg_data;
                CFG_INTEG_HIGH:  ihigh_reg   <= cfg_data;
                CFG_INPUT_RANGE: range_reg   <= cfg_data[31:0];
                CFG_POS_TOL:     pos_tol_reg <= cfg_data[30:0];
                default:         kp_reg      <= kp_reg;
            endcase
        end
    end

    // Controller state: last error and integral
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_error_reg <= '0;
            integral_reg   <= '0;
        end
        else
        begin
            if (state_reg == S_VEL)
            begin
                last_error_reg <= e32_reg;
            end
            if (state_reg == S_IZ && e_abs > 33'(izone_reg))
            begin
                integral_reg <= '0;
            end
            else if (state_reg == S_ID_W && div_done)
            begin
                integral_reg <= iclamp;
            end
        end
    end

    // Datapath working registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    e_reg  <= 35'(setpoint) - 35'(measurement);
                    dt_reg <= dt_ticks;
                    zi_reg <= (dt_ticks == '0);
                end
            end
            S_WA:
            begin
                neg_reg <= (xa < 0);
            end
            S_WA_W:
            begin
                if (div_done)
                begin
                    e_reg <= lo_s + srem;
                end
            end
            S_WB:
            begin
                neg_reg <= (xb < 0);
            end
            S_WB_W:
            begin
                if (div_done)
                begin
                    e_reg <= hi_s + srem;
                end
            end
            S_SAT:
            begin
                e32_reg <= sat32(64'(e_reg));
            end
            S_VEL:
            begin
                neg_reg <= (num < 0);
                v_reg   <= '0;
            end
            S_VEL_W:
            begin
                if (div_done)
                begin
                    v_reg <= sat32(64'(sq));
                end
            end
            S_IM_W:
            begin
                if (mul_done)
                begin
                    neg_reg  <= (mul_prod < 0);
                    pmag_reg <= 52'(mul_prod < 0 ? -mul_prod : mul_prod);
                end
            end
            S_MP:
            begin
                acc_reg <= '0;
            end
            S_MP_W, S_MD_W:
            begin
                if (mul_done)
                begin
                    acc_reg <= acc_reg + prod_sh;
                end
            end
            S_MI_W:
            begin
                if (mul_done)
                begin
                    acc_reg <= acc_reg + ti_sat;
                end
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    // Result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == S_OUT && res_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT && res_free)
        begin
            if (acc_reg > MAX48)
            begin
                drive_reg <= MAX48[47:0];
            end
            else if (acc_reg < MIN48)
            begin
                drive_reg <= MIN48[47:0];
            end
            else
            begin
                drive_reg <= acc_reg[47:0];
            end
            at_reg <= (e_abs < 33'(pos_tol_reg)) && (v_abs < $signed(VTOL_U));
            zo_reg <= zi_reg;
        end
    end

    pcs_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    pcs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quo      (div_quo),
        .rem      (div_rem)
    );

    assign in_stall      = (state_reg != S_IDLE);
    assign cfg_ready     = 1'b1;
    assign out_valid     = out_valid_reg;
    assign drive         = drive_reg;
    assign at_setpoint   = at_reg;
    assign zero_interval = zo_reg;

endmodule
`default_nettype wire

// ----- hdl/pcs_checker.sv -----
// Port-level checker for the PID controller step, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "pid_controller_step_defines.svh"
module pcs_checker
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_stall,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire logic signed [47:0] drive,
    input wire logic               cfg_ready
);

    `PCS_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)
    `PCS_ASSERT_NXT(a_drive_hold, out_valid && out_stall, $stable(drive))
    `PCS_ASSERT_NXT(a_busy_after_req, in_valid && !in_stall, in_stall)
    `PCS_ASSERT_IMP(a_result_from_busy, $rose(out_valid), $past(in_stall) && cfg_ready)

endmodule

bind pid_controller_step pcs_checker u_pcs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .drive     (drive),
    .cfg_ready (cfg_ready)
);
`default_nettype wire
